[src/sm4_pkg.sv]
// SM4 package: mode codes, register indices, FK constants, S-box, round helpers.
// Used by sm4_cipher_engine_with_modes_core. No dependencies.
package sm4_pkg;

  typedef enum logic [1:0] {
    MODE_ECB   = 2'd0,
    MODE_CBC   = 2'd1,
    MODE_CTR   = 2'd2,
    MODE_CTR32 = 2'd3
  } mode_t;

  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;
  localparam logic [2:0] REG_DIR      = 3'd5;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;
  localparam logic [7:0]  CK_STEP = 8'h07;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // linear layer of the data path
  function automatic logic [31:0] lin_enc(input logic [31:0] t);
    return t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]} ^ {t[13:0], t[31:14]}
             ^ {t[7:0], t[31:8]};
  endfunction

  // linear layer of the key schedule
  function automatic logic [31:0] lin_key(input logic [31:0] t);
    return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
  endfunction

  // CK word i: byte j = (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [4:0] i);
    logic [7:0] b;
    logic [31:0] w;
    b = {1'b0, i, 2'b00} * CK_STEP;
    w = {b, b + CK_STEP, b + 8'(2 * CK_STEP), b + 8'(3 * CK_STEP)};
    return w;
  endfunction

endpackage

[src/sm4_cipher_engine_with_modes_core.sv]
// SM4 engine top level: key schedule, 32-round data path, ECB/CBC/CTR/CTR32 modes.
// Round keys and chaining value sit in synchronous memories. Uses sm4_pkg.
// An accepted word passes load and round-key read, 32 rounds and mode arithmetic
// before out_tvalid; the first word after a key write waits for key expansion.
// A single round unit takes one word at a time, none while it works; a new word is
// taken while a result waits. Reset (rst_n, sync) clears regs and chain valid bits.
module sm4_cipher_engine_with_modes_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // block_high[63:0], block_low[127:64]
  input  logic         in_tuser,   // first_block
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // result_high[63:0], result_low[127:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_KEXP  = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  sm4_pkg::mode_t mode_r;
  logic dir_r, keys_ready_r;

  logic [31:0] rk_mem [32];
  logic [63:0] cv_mem [2];
  logic [1:0]  cv_valid_r;
  logic [31:0] rk_rd_r;
  logic [63:0] cv_rd_hi_r, cv_rd_lo_r;

  logic [5:0]  cnt_r;
  logic [31:0] x0_r, x1_r, x2_r, x3_r;
  logic [63:0] bh_r, bl_r;
  logic        first_r;
  logic [127:0] out_r;
  logic         out_v_r;

  logic [63:0] cv_hi, cv_lo, cv_hi_new, cv_lo_new, res_hi, res_lo;
  logic [31:0] t_key, t_dat;
  logic [4:0]  rk_addr;
  logic        cv_wr;
  logic        done_go;

  assign cfg_ready  = (state_r == ST_IDLE) && !out_v_r;
  assign in_tready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;
  // finishing waits until the output register is free
  assign done_go    = !out_v_r || out_tready;

  // chain value in use: reload on first block, else memory or zero
  always_comb begin
    if (first_r) begin
      cv_hi = iv_high_r;
      cv_lo = iv_low_r;
    end else begin
      cv_hi = cv_valid_r[0] ? cv_rd_hi_r : 64'd0;
      cv_lo = cv_valid_r[1] ? cv_rd_lo_r : 64'd0;
    end
  end

  assign t_key = sm4_pkg::lin_key(sm4_pkg::tau(x1_r ^ x2_r ^ x3_r ^
                                  sm4_pkg::ck_word(cnt_r[4:0])));
  assign t_dat = sm4_pkg::lin_enc(sm4_pkg::tau(x1_r ^ x2_r ^ x3_r ^ rk_rd_r));

  // read address runs one ahead of the round in use
  always_comb begin
    logic [4:0] a;
    a = (state_r == ST_ROUND) ? cnt_r[4:0] + 5'd1 : 5'd0;
    rk_addr = (dir_r && mode_r != sm4_pkg::MODE_CTR && mode_r != sm4_pkg::MODE_CTR32)
              ? ~a : a;
  end

  // final mode arithmetic at ST_DONE; x holds the round output
  always_comb begin
    logic [63:0] ch, cl;
    ch = {x3_r, x2_r};
    cl = {x1_r, x0_r};
    cv_hi_new = cv_hi;
    cv_lo_new = cv_lo;
    cv_wr = first_r;
    unique case (mode_r)
      sm4_pkg::MODE_ECB: begin
        res_hi = ch;
        res_lo = cl;
      end
      sm4_pkg::MODE_CBC: begin
        cv_wr = 1'b1;
        if (!dir_r) begin
          res_hi = ch;
          res_lo = cl;
          cv_hi_new = ch;
          cv_lo_new = cl;
        end else begin
          res_hi = ch ^ cv_hi;
          res_lo = cl ^ cv_lo;
          cv_hi_new = bh_r;
          cv_lo_new = bl_r;
        end
      end
      sm4_pkg::MODE_CTR: begin
        cv_wr = 1'b1;
        res_hi = ch ^ bh_r;
        res_lo = cl ^ bl_r;
        {cv_hi_new, cv_lo_new} = {cv_hi, cv_lo} + 128'd1;
      end
      default: begin
        cv_wr = 1'b1;
        res_hi = ch ^ bh_r;
        res_lo = cl ^ bl_r;
        cv_lo_new = {cv_lo[63:32], cv_lo[31:0] + 32'd1};
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid && in_tready) state_nxt = keys_ready_r ? ST_LOAD : ST_KEXP;
      ST_KEXP:  if (cnt_r == 6'd31) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (cnt_r == 6'd31) state_nxt = ST_DONE;
      ST_DONE:  if (done_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_high_r <= '0; key_low_r <= '0; iv_high_r <= '0; iv_low_r <= '0;
      mode_r <= sm4_pkg::MODE_ECB;
      dir_r <= 1'b0;
      keys_ready_r <= 1'b0;
      cv_valid_r <= '0;
      out_v_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sm4_pkg::REG_KEY_HIGH: begin key_high_r <= cfg_data; keys_ready_r <= 1'b0; end
          sm4_pkg::REG_KEY_LOW:  begin key_low_r <= cfg_data; keys_ready_r <= 1'b0; end
          sm4_pkg::REG_IV_HIGH:  iv_high_r <= cfg_data;
          sm4_pkg::REG_IV_LOW:   iv_low_r <= cfg_data;
          sm4_pkg::REG_MODE:     mode_r <= sm4_pkg::mode_t'(cfg_data[1:0]);
          sm4_pkg::REG_DIR:      dir_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == ST_DONE && done_go) out_v_r <= 1'b1;
      else if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        ST_KEXP: begin
          cnt_r <= (cnt_r == 6'd31) ? 6'd0 : cnt_r + 6'd1;
          if (cnt_r == 6'd31) keys_ready_r <= 1'b1;
        end
        ST_ROUND: cnt_r <= (cnt_r == 6'd31) ? 6'd0 : cnt_r + 6'd1;
        ST_DONE: begin
          if (done_go && cv_wr) cv_valid_r <= 2'b11;
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  // data path and memories
  always_ff @(posedge clk) begin
    rk_rd_r <= rk_mem[rk_addr];
    cv_rd_hi_r <= cv_mem[0];
    cv_rd_lo_r <= cv_mem[1];
    unique case (state_r)
      ST_IDLE: begin
        bh_r <= in_tdata[63:0];
        bl_r <= in_tdata[127:64];
        first_r <= in_tuser;
        x0_r <= key_high_r[63:32] ^ sm4_pkg::FK0;
        x1_r <= key_high_r[31:0]  ^ sm4_pkg::FK1;
        x2_r <= key_low_r[63:32]  ^ sm4_pkg::FK2;
        x3_r <= key_low_r[31:0]   ^ sm4_pkg::FK3;
      end
      ST_KEXP: begin
        rk_mem[cnt_r[4:0]] <= x0_r ^ t_key;
        {x0_r, x1_r, x2_r, x3_r} <= {x1_r, x2_r, x3_r, x0_r ^ t_key};
      end
      ST_LOAD: begin
        if (mode_r == sm4_pkg::MODE_ECB || (mode_r == sm4_pkg::MODE_CBC && dir_r))
          {x0_r, x1_r, x2_r, x3_r} <= {bh_r, bl_r};
        else if (mode_r == sm4_pkg::MODE_CBC)
          {x0_r, x1_r, x2_r, x3_r} <= {bh_r ^ cv_hi, bl_r ^ cv_lo};
        else
          {x0_r, x1_r, x2_r, x3_r} <= {cv_hi, cv_lo};
      end
      ST_ROUND: {x0_r, x1_r, x2_r, x3_r} <= {x1_r, x2_r, x3_r, x0_r ^ t_dat};
      ST_DONE: begin
        if (done_go) begin
          out_r <= {res_lo, res_hi};
          if (cv_wr) begin
            cv_mem[0] <= cv_hi_new;
            cv_mem[1] <= cv_lo_new;
          end
        end
      end
      default: ;
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second word accepted");
  a_done_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_v_r) else $error("result lost");
  a_keys_before_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> keys_ready_r) else $error("rounds without keys");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !cfg_ready) else $error("config during work");

endmodule
